// ----- hw/rtl/ttw_pkg.sv -----
// ----------------------------------------------------------------------------
// ttw_pkg
// shared types, codes and constants of the translation table walker
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam int TABLE_PAGES_DEF = 16;
  localparam int ENTRY_W         = 9;
  localparam int WORDS_PER_TABLE = 512;
  localparam int DESC_W          = 64;
  localparam int FRAME_W         = 36;
  localparam int VA_W            = 39;
  localparam int PA_W            = 48;
  localparam int OFFSET_W        = 12;
  localparam int WIDX_W          = 13;
  localparam int ROOT_W          = 4;
  localparam int STATUS_W        = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 36;
  localparam int IN_DATA_W       = 120;
  localparam int OUT_DATA_W      = 56;

  localparam logic [FRAME_W-1:0] BASE_FRAME_RST = 36'd262144;
  localparam logic [1:0]         KIND_TABLE     = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_PAGE  = 1'b0,
    REG_BASE_FRAME = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD1    = 3'd1,
    ST_BAD2    = 3'd2,
    ST_BAD3    = 3'd3,
    ST_OUTSIDE = 3'd4
  } status_t;

  typedef enum logic {
    CMD_WRITE     = 1'b0,
    CMD_TRANSLATE = 1'b1
  } command_t;

  typedef struct packed {
    logic good;
    logic in_store;
  } chk_t;

endpackage

// ----- hw/rtl/three_level_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// three_level_page_table_walker
// three-level 4 kb granule table walk over a local descriptor store
// ----------------------------------------------------------------------------
// After reset the block zeroes its table store, one word a cycle, and takes
// no item meanwhile. A write item stores one descriptor, when its word index
// lies inside the store, and returns a result. A translate item reads one
// descriptor per level from the single-port store, through S_L1, S_L2 and
// S_L3, and ends early when it faults; the store port and one shared
// descriptor check unit serve every level. One item is in flight at a time;
// a result that finds the output busy waits in the pending registers.
module three_level_page_table_walker
  import ttw_pkg::*;
#(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // va, word index, word data, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pa, status, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int STORE_WORDS = TABLE_PAGES * WORDS_PER_TABLE;
  localparam int RAM_AW      = $clog2(STORE_WORDS);
  localparam int LIN_W       = PAGE_W + ENTRY_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_L1    = 6'b000100,
    S_L2    = 6'b001000,
    S_L3    = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [ROOT_W-1:0]   root_table_page;
  logic [FRAME_W-1:0]  store_base_frame;
  logic [RAM_AW-1:0]   clear_addr;
  logic [VA_W-1:0]     va;
  logic [PA_W-1:0]     pend_pa;
  logic [STATUS_W-1:0] pend_st;

  logic [VA_W-1:0]     in_va;
  logic [WIDX_W-1:0]   in_widx;
  logic [DESC_W-1:0]   in_data;
  logic                accept;
  logic                slot_free;
  logic                root_ok;
  logic                widx_ok;

  logic                ram_en, ram_we;
  logic [RAM_AW-1:0]   ram_addr;
  logic [DESC_W-1:0]   ram_wdata, ram_rdata;

  chk_t                chk;
  logic [PAGE_W-1:0]   chk_page;

  logic                fin;
  logic [PA_W-1:0]     fin_pa;
  logic [STATUS_W-1:0] fin_st;

  assign in_va     = s_tdata[VA_W-1:0];
  assign in_widx   = s_tdata[VA_W+WIDX_W-1:VA_W];
  assign in_data   = s_tdata[VA_W+WIDX_W+DESC_W-1:VA_W+WIDX_W];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign root_ok   = 32'(root_table_page) < 32'(TABLE_PAGES);
  assign widx_ok   = 32'(in_widx) < 32'(STORE_WORDS);

  ttw_ram #(
    .WIDTH (DESC_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ttw_entry_unit #(
    .TABLE_PAGES (TABLE_PAGES),
    .PAGE_W      (PAGE_W)
  ) u_check (
    .desc       (ram_rdata),
    .base_frame (store_base_frame),
    .chk        (chk),
    .page       (chk_page)
  );

  always_comb begin
    state_next = state;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = '0;
    ram_wdata  = '0;
    fin        = 1'b0;
    fin_pa     = '0;
    fin_st     = ST_OK;
    unique case (state)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clear_addr;
        if (clear_addr == RAM_AW'(STORE_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == CMD_WRITE) begin
            ram_en    = widx_ok;
            ram_we    = 1'b1;
            ram_addr  = RAM_AW'(32'(in_widx));
            ram_wdata = in_data;
            fin       = 1'b1;
          end else if (!root_ok) begin
            fin    = 1'b1;
            fin_st = ST_OUTSIDE;
          end else begin
            ram_en     = 1'b1;
            ram_addr   = RAM_AW'({PAGE_W'(root_table_page), in_va[38:30]});
            state_next = S_L1;
          end
        end
      end
      S_L1: begin
        if (!chk.good) begin
          fin    = 1'b1;
          fin_st = ST_BAD1;
        end else if (!chk.in_store) begin
          fin    = 1'b1;
          fin_st = ST_OUTSIDE;
        end else begin
          ram_en     = 1'b1;
          ram_addr   = RAM_AW'(LIN_W'({chk_page, va[29:21]}));
          state_next = S_L2;
        end
      end
      S_L2: begin
        if (!chk.good) begin
          fin    = 1'b1;
          fin_st = ST_BAD2;
        end else if (!chk.in_store) begin
          fin    = 1'b1;
          fin_st = ST_OUTSIDE;
        end else begin
          ram_en     = 1'b1;
          ram_addr   = RAM_AW'(LIN_W'({chk_page, va[20:12]}));
          state_next = S_L3;
        end
      end
      S_L3: begin
        fin = 1'b1;
        if (!chk.good) begin
          fin_st = ST_BAD3;
        end else begin
          fin_pa = {ram_rdata[PA_W-1:OFFSET_W], va[OFFSET_W-1:0]};
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = slot_free ? S_IDLE : S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clear_addr       <= '0;
      root_table_page  <= '0;
      store_base_frame <= BASE_FRAME_RST;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROOT_PAGE:  root_table_page  <= cfg_data[ROOT_W-1:0];
          REG_BASE_FRAME: store_base_frame <= cfg_data[FRAME_W-1:0];
          default: ;
        endcase
      end
      if ((fin && slot_free) || (state == S_EMIT && slot_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      va <= in_va;
    end
    if (fin && !slot_free) begin
      pend_pa <= fin_pa;
      pend_st <= fin_st;
    end
    if (fin && slot_free) begin
      m_tdata <= OUT_DATA_W'({fin_st, fin_pa});
    end else if (state == S_EMIT && slot_free) begin
      m_tdata <= OUT_DATA_W'({pend_st, pend_pa});
    end
  end

endmodule

// ----- hw/rtl/ttw_ram.sv -----
// ----------------------------------------------------------------------------
// ttw_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module ttw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hw/rtl/ttw_entry_unit.sv -----
// ----------------------------------------------------------------------------
// ttw_entry_unit
// descriptor check: kind test and frame to store page subtract and compare
// ----------------------------------------------------------------------------
module ttw_entry_unit
  import ttw_pkg::*;
#(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF,
  parameter int PAGE_W      = 4
) (
  input  logic [DESC_W-1:0]  desc,
  input  logic [FRAME_W-1:0] base_frame,
  output chk_t               chk,
  output logic [PAGE_W-1:0]  page
);

  logic [FRAME_W-1:0] frame;
  logic [FRAME_W:0]   diff;

  assign frame        = desc[PA_W-1:OFFSET_W];
  assign diff         = {1'b0, frame} - {1'b0, base_frame};
  assign chk.good     = (desc != '0) && (desc[1:0] == KIND_TABLE);
  assign chk.in_store = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(TABLE_PAGES));
  assign page         = diff[PAGE_W-1:0];

endmodule
